// File: hw/rtl/hmm_mel_pkg.sv
`default_nettype none

package hmm_mel_pkg;

  // topology limits
  localparam int unsigned MaxStates = 16;
  localparam int unsigned MaxEdges  = 64;

  // derived widths
  localparam int unsigned StIdxW   = $clog2(MaxStates);
  localparam int unsigned StCntW   = $clog2(MaxStates + 1);
  localparam int unsigned EdgeIdxW = $clog2(MaxEdges);
  localparam int unsigned EdgeCntW = $clog2(MaxEdges + 1);
  localparam int unsigned DistW    = $clog2(MaxStates + 1);
  localparam int unsigned EdgeW    = 2 * StIdxW;

  // item kinds
  localparam logic ActState = 1'b0;
  localparam logic ActEdge  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_EDGE_RD,
    ST_DIST_RD,
    ST_RELAX,
    ST_FIN_RD,
    ST_FIN
  } state_e;

  // per-cycle controls from the sequencer
  typedef struct packed {
    logic load;
    logic init;
    logic edge_rd;
    logic dist_rd;
    logic relax;
    logic fin_rd;
    logic fin;
  } ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/hmm_topology_min_emitting_length.sv
// Minimum emitting length of one HMM topology.
// Input channel (in_valid_i / in_stall_o): one load item per cycle while
// in_stall_o is low. A state item sets whether a state emits, an edge item
// appends a transition to the edge memory (edges past the memory depth are
// dropped). The item with last_i set is stored like the others and then starts the relaxation.
// Relaxation: one shared compare/add unit visits the stored edges in order,
// each edge through an edge memory read, a distance memory read and a
// compare/write, and repeats full passes until a pass changes nothing, with
// at most one pass per state (the pass that changes nothing included). The
// block stalls its input while it relaxes.
// Output channel (out_valid_o / out_stall_i): one item per last item, holding
// min_length_o and reachable_o in an output register. While it waits, load
// items are still taken; only a new last item is held off until it leaves.
// After each result the emit flags and the edge and state counts return to their reset values.
// Reset: asynchronous, active low; the block comes up empty and ready.
`default_nettype none

module hmm_topology_min_emitting_length (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                action_i,
  input  wire logic [hmm_mel_pkg::StIdxW-1:0]      state_index_i,
  input  wire logic [hmm_mel_pkg::StIdxW-1:0]      target_state_i,
  input  wire logic                                emitting_i,
  input  wire logic                                last_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [hmm_mel_pkg::DistW-1:0]            min_length_o,
  output logic                                     reachable_o
);

  localparam int unsigned StIdxW   = hmm_mel_pkg::StIdxW;
  localparam int unsigned StCntW   = hmm_mel_pkg::StCntW;
  localparam int unsigned EdgeIdxW = hmm_mel_pkg::EdgeIdxW;
  localparam int unsigned EdgeCntW = hmm_mel_pkg::EdgeCntW;
  localparam int unsigned DistW    = hmm_mel_pkg::DistW;
  localparam int unsigned EdgeW    = hmm_mel_pkg::EdgeW;
  localparam int unsigned NSt      = hmm_mel_pkg::MaxStates;
  localparam int unsigned NEdge    = hmm_mel_pkg::MaxEdges;

  hmm_mel_pkg::state_e state_q, state_d;
  hmm_mel_pkg::ctrl_t  ctrl;

  logic                  in_acc;
  logic [NSt-1:0]        emit_q;
  logic [NSt-1:0]        dist_vld_q;
  logic [EdgeCntW-1:0]   edge_cnt_q;
  logic [StCntW-1:0]     st_cnt_q;
  logic [EdgeIdxW-1:0]   edge_idx_q;
  logic                  changed_q;
  logic                  out_vld_q;
  logic [DistW-1:0]      out_len_q;
  logic                  out_reach_q;

  // memories
  logic [EdgeW-1:0]      edge_mem [NEdge];
  logic [EdgeW-1:0]      edge_rd_q;
  logic [DistW-1:0]      dist_mem [NSt];
  logic [DistW-1:0]      dist_a_q, dist_b_q;
  logic                  vld_a_q, vld_b_q;

  logic                  edge_we;
  logic [EdgeW-1:0]      edge_wdata;
  logic [StIdxW-1:0]     e_src, e_dst, fin_st;
  logic [StIdxW-1:0]     raddr_a;
  logic                  dist_we;
  logic [StIdxW-1:0]     dist_waddr;
  logic [DistW-1:0]      dist_wdata;
  logic [DistW-1:0]      cand;
  logic                  better;
  logic                  last_edge;
  logic                  no_edges;
  logic [StCntW-1:0]     idx_cnt, tgt_cnt, st_cnt_d;

  // handshake
  assign in_stall_o  = (state_q != hmm_mel_pkg::ST_LOAD) || (out_vld_q && last_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign min_length_o = out_len_q;
  assign reachable_o  = out_reach_q;

  // edge fields and derived indexes
  assign e_src     = edge_rd_q[StIdxW-1:0];
  assign e_dst     = edge_rd_q[EdgeW-1:StIdxW];
  assign fin_st    = (st_cnt_q == '0) ? '0 : StIdxW'(st_cnt_q - StCntW'(1));
  assign raddr_a   = ctrl.fin_rd ? fin_st : e_src;
  assign last_edge = ({1'b0, edge_idx_q} == EdgeCntW'(edge_cnt_q - EdgeCntW'(1)));
  assign no_edges  = (edge_cnt_q == '0);

  // candidate length through the current edge
  assign cand   = dist_a_q + DistW'(emit_q[e_dst]);
  assign better = vld_a_q && (!vld_b_q || (cand < dist_b_q));

  // load path
  assign edge_we    = ctrl.load && in_acc && (action_i == hmm_mel_pkg::ActEdge) &&
                      (edge_cnt_q < EdgeCntW'(NEdge));
  assign edge_wdata = {target_state_i, state_index_i};
  assign idx_cnt    = StCntW'(state_index_i) + StCntW'(1);
  assign tgt_cnt    = StCntW'(target_state_i) + StCntW'(1);

  // state count: grows on loads, back to zero with the result
  always_comb begin
    st_cnt_d = st_cnt_q;
    if (ctrl.fin) begin
      st_cnt_d = '0;
    end else if (ctrl.load && in_acc) begin
      if (action_i == hmm_mel_pkg::ActState) begin
        if (idx_cnt > st_cnt_d) st_cnt_d = idx_cnt;
      end else if (edge_we) begin
        if (idx_cnt > st_cnt_d) st_cnt_d = idx_cnt;
        if (tgt_cnt > st_cnt_d) st_cnt_d = tgt_cnt;
      end
    end
  end

  // distance write port
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = e_dst;
    dist_wdata = cand;
    if (ctrl.init) begin
      dist_we    = 1'b1;
      dist_waddr = '0;
      dist_wdata = DistW'(emit_q[0]);
    end else if (ctrl.relax && better) begin
      dist_we = 1'b1;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hmm_mel_pkg::ST_LOAD: begin
        if (in_acc && last_i) state_d = hmm_mel_pkg::ST_INIT;
      end
      hmm_mel_pkg::ST_INIT: begin
        state_d = no_edges ? hmm_mel_pkg::ST_FIN_RD : hmm_mel_pkg::ST_EDGE_RD;
      end
      hmm_mel_pkg::ST_EDGE_RD: state_d = hmm_mel_pkg::ST_DIST_RD;
      hmm_mel_pkg::ST_DIST_RD: state_d = hmm_mel_pkg::ST_RELAX;
      hmm_mel_pkg::ST_RELAX: begin
        if (!last_edge) begin
          state_d = hmm_mel_pkg::ST_EDGE_RD;
        end else if (changed_q || better) begin
          state_d = hmm_mel_pkg::ST_EDGE_RD;
        end else begin
          state_d = hmm_mel_pkg::ST_FIN_RD;
        end
      end
      hmm_mel_pkg::ST_FIN_RD: state_d = hmm_mel_pkg::ST_FIN;
      hmm_mel_pkg::ST_FIN:    state_d = hmm_mel_pkg::ST_LOAD;
      default:                state_d = hmm_mel_pkg::ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      hmm_mel_pkg::ST_LOAD:    ctrl.load    = 1'b1;
      hmm_mel_pkg::ST_INIT:    ctrl.init    = 1'b1;
      hmm_mel_pkg::ST_EDGE_RD: ctrl.edge_rd = 1'b1;
      hmm_mel_pkg::ST_DIST_RD: ctrl.dist_rd = 1'b1;
      hmm_mel_pkg::ST_RELAX:   ctrl.relax   = 1'b1;
      hmm_mel_pkg::ST_FIN_RD:  ctrl.fin_rd  = 1'b1;
      hmm_mel_pkg::ST_FIN:     ctrl.fin     = 1'b1;
      default:                 ctrl         = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmm_mel_pkg::ST_LOAD;
      emit_q      <= '0;
      dist_vld_q  <= '0;
      edge_cnt_q  <= '0;
      st_cnt_q    <= '0;
      edge_idx_q  <= '0;
      changed_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_cnt_q <= st_cnt_d;
      // load items
      if (ctrl.load && in_acc && (action_i == hmm_mel_pkg::ActState)) begin
        emit_q[state_index_i] <= emitting_i;
      end
      if (edge_we) edge_cnt_q <= edge_cnt_q + EdgeCntW'(1);
      // start of relaxation: only the start state is reached
      if (ctrl.init) begin
        dist_vld_q    <= NSt'(1);
        edge_idx_q    <= '0;
        changed_q     <= 1'b0;
      end
      // step through edges, one pass after another
      if (ctrl.relax) begin
        if (better) dist_vld_q[e_dst] <= 1'b1;
        if (last_edge) begin
          edge_idx_q <= '0;
          changed_q  <= 1'b0;
        end else begin
          edge_idx_q <= edge_idx_q + EdgeIdxW'(1);
          changed_q  <= changed_q || better;
        end
      end
      // result out, store back to empty
      if (ctrl.fin) begin
        out_vld_q  <= 1'b1;
        emit_q     <= '0;
        edge_cnt_q <= '0;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (ctrl.fin) begin
      out_reach_q <= vld_a_q;
      out_len_q   <= vld_a_q ? dist_a_q : '0;
    end
  end

  // edge memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_cnt_q[EdgeIdxW-1:0]] <= edge_wdata;
    if (ctrl.edge_rd) edge_rd_q <= edge_mem[edge_idx_q];
  end

  // distance memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (ctrl.dist_rd || ctrl.fin_rd) begin
      dist_a_q <= dist_mem[raddr_a];
      dist_b_q <= dist_mem[e_dst];
      vld_a_q  <= dist_vld_q[raddr_a];
      vld_b_q  <= dist_vld_q[e_dst];
    end
  end

  // checks
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == hmm_mel_pkg::ST_FIN))
    else $error("result item raised outside the finish step");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != hmm_mel_pkg::ST_LOAD) |-> in_stall_o)
    else $error("input taken while relaxation runs");

  a_edge_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_cnt_q <= EdgeCntW'(NEdge))
    else $error("edge count past memory depth");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hmm_mel_pkg::ST_FIN) |=> (edge_cnt_q == '0 && st_cnt_q == '0 && emit_q == '0))
    else $error("store not cleared after result");

endmodule

`default_nettype wire
